// ===== hw/rtl/tem_pkg.sv =====
`default_nettype none

package tem_pkg;

   typedef enum logic [1:0] {
      KIND_GLYPH   = 2'd0,
      KIND_NEWLINE = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   localparam logic CSR_LAYOUT_MODE  = 1'b0;
   localparam logic CSR_LINE_ADVANCE = 1'b1;

   localparam logic [7:0]  LINE_ADVANCE_RESET = 8'd16;
   localparam logic [15:0] U16_MAX            = 16'hFFFF;
   localparam logic [16:0] PEN_MAX            = 17'h1FFFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] advance;
      logic [7:0] left_offset;
      logic [7:0] ink_width;
      logic [7:0] ink_height;
      logic [7:0] top_offset;
   } item_type;

   typedef struct packed {
      logic       line_layout_mode;
      logic [7:0] line_advance;
   } cfg_type;

   typedef struct packed {
      logic [15:0] text_width;
      logic [15:0] text_height;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tem_accum.sv =====
`default_nettype none

module tem_accum
   import tem_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic [16:0] line_pen_ff, line_pen_in;
   logic [15:0] longest_line_ff, longest_line_in;
   logic [7:0]  max_rise_ff, max_rise_in;
   logic [8:0]  max_drop_ff, max_drop_in;
   logic [15:0] line_total_ff, line_total_in;

   logic [17:0]        pen_sum;
   logic [16:0]        pen_sat;
   logic signed [18:0] ink_right;
   logic [15:0]        ink_right_sat;
   logic signed [8:0]  rise;
   logic signed [9:0]  drop;
   logic [23:0]        lines_product;
   logic [24:0]        lines_height;
   logic [15:0]        height;

   always_comb begin
      pen_sum = {1'b0, line_pen_ff} + {10'd0, item.advance};
      pen_sat = pen_sum[17] ? PEN_MAX : pen_sum[16:0];

      // The line reaches the right edge of the ink, which may overhang the pen.
      ink_right = $signed({2'b00, pen_sat})
                + $signed({{11{item.left_offset[7]}}, item.left_offset})
                + $signed({11'd0, item.ink_width})
                - $signed({11'd0, item.advance});
      if (ink_right[18])
         ink_right_sat = 16'd0;
      else if (ink_right[17:16] != 2'b00)
         ink_right_sat = U16_MAX;
      else
         ink_right_sat = ink_right[15:0];

      rise = -$signed({item.top_offset[7], item.top_offset});
      drop = $signed({2'b00, item.ink_height})
           + $signed({{2{item.top_offset[7]}}, item.top_offset});

      lines_product = line_total_ff * cfg.line_advance;
      lines_height  = {1'b0, lines_product} + {16'd0, max_drop_ff};
      if (cfg.line_layout_mode)
         height = (lines_height[24:16] != 9'd0) ? U16_MAX : lines_height[15:0];
      else
         height = {8'd0, max_rise_ff} + {7'd0, max_drop_ff};

      result.text_width  = longest_line_ff;
      result.text_height = height;
   end

   always_comb begin
      line_pen_in     = line_pen_ff;
      longest_line_in = longest_line_ff;
      max_rise_in     = max_rise_ff;
      max_drop_in     = max_drop_ff;
      line_total_in   = line_total_ff;
      if (step) begin
         case (item.kind)
            KIND_GLYPH: begin
               line_pen_in = pen_sat;
               if (ink_right_sat > longest_line_ff)
                  longest_line_in = ink_right_sat;
               if (rise > $signed({1'b0, max_rise_ff}))
                  max_rise_in = rise[7:0];
               if (drop > $signed({1'b0, max_drop_ff}))
                  max_drop_in = drop[8:0];
            end
            KIND_NEWLINE: begin
               if (line_total_ff != U16_MAX)
                  line_total_in = line_total_ff + 16'd1;
               line_pen_in = 17'd0;
               max_drop_in = 9'd0;
            end
            KIND_END: begin
               line_pen_in     = 17'd0;
               longest_line_in = 16'd0;
               max_rise_in     = 8'd0;
               max_drop_in     = 9'd0;
               line_total_in   = 16'd1;
            end
            default: begin
               // An unused kind leaves the state alone.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pen_ff     <= 17'd0;
         longest_line_ff <= 16'd0;
         max_rise_ff     <= 8'd0;
         max_drop_ff     <= 9'd0;
         line_total_ff   <= 16'd1;
      end else begin
         line_pen_ff     <= line_pen_in;
         longest_line_ff <= longest_line_in;
         max_rise_ff     <= max_rise_in;
         max_drop_ff     <= max_drop_in;
         line_total_ff   <= line_total_in;
      end
   end

`ifndef SYNTHESIS
   a_line_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_total_ff != 16'd0)
      else $error("line count reached zero");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && item.kind == KIND_END |=>
         line_pen_ff == 17'd0 && longest_line_ff == 16'd0 && max_rise_ff == 8'd0 &&
         max_drop_ff == 9'd0 && line_total_ff == 16'd1)
      else $error("end of text did not clear the state");

   a_newline_keeps_width: assert property (@(posedge clock) disable iff (reset)
      step && item.kind == KIND_NEWLINE |=>
         line_pen_ff == 17'd0 && max_drop_ff == 9'd0 && $stable(longest_line_ff))
      else $error("newline update is wrong");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/text_extent_measure_top.sv =====
// Text extent measurement for a proportional font.
// Requests arrive on the req_ channel, one per character: req_tuser carries
// the kind (glyph, newline, end of text) and req_tdata the glyph metrics,
// which are ignored for newline and end requests. Each glyph moves the pen,
// widens the longest line to the right edge of its ink and widens the rise
// and drop. An end request produces one response on the rsp_ channel with
// the width and height (both saturated to 16 bits) and clears the running
// state; glyph and newline requests produce no response.
// Throughput is one request per cycle: the request register feeds one pass
// of adders, compares and a 16x8 multiply into the accumulators and the
// response register, where an end request's result is registered. When
// the receiver stalls, the held response stops the next end request in the
// request register, and the input waits behind it; glyphs and newlines
// ahead of that end request keep flowing.
// The csr_ port sets the height mode and the line advance; write it only
// while the block is idle. Synchronous reset clears the measurement, sets
// height mode 0 and a line advance of 16, and empties both registers.
`default_nettype none

module text_extent_measure_top
   import tem_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // advance, left_offset, ink_width, ink_height, top_offset (8 bits each)
   input  wire logic [39:0] req_tdata,
   // kind
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // text_width [15:0], text_height [31:16]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic       req_valid_ff, req_valid_in;
   item_type   req_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   cfg_type    cfg_ff;
   result_type result;
   logic       out_free;
   logic       step;
   logic       req_accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = req_valid_ff && (req_item_ff.kind != KIND_END || out_free);
   assign req_tready = !req_valid_ff || step;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      req_valid_in = req_accept ? 1'b1 : (step ? 1'b0 : req_valid_ff);
      if (step && req_item_ff.kind == KIND_END)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_item_ff.kind        <= req_tuser;
         req_item_ff.advance     <= req_tdata[7:0];
         req_item_ff.left_offset <= req_tdata[15:8];
         req_item_ff.ink_width   <= req_tdata[23:16];
         req_item_ff.ink_height  <= req_tdata[31:24];
         req_item_ff.top_offset  <= req_tdata[39:32];
      end
      if (step && req_item_ff.kind == KIND_END)
         rsp_data_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_layout_mode <= 1'b0;
         cfg_ff.line_advance     <= LINE_ADVANCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LAYOUT_MODE:  cfg_ff.line_layout_mode <= csr_wdata[0];
            CSR_LINE_ADVANCE: cfg_ff.line_advance     <= csr_wdata;
            default:          cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   tem_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.text_height, rsp_data_ff.text_width};

`ifndef SYNTHESIS
   a_end_waits: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && req_item_ff.kind == KIND_END && rsp_valid_ff && !rsp_tready
         |-> !req_tready)
      else $error("end request taken while the response is stalled");

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      step && req_item_ff.kind == KIND_END |=> rsp_tvalid)
      else $error("end request produced no response");

   a_glyph_flows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && req_item_ff.kind != KIND_END |-> req_tready)
      else $error("non-end request stalled the input");
`endif

endmodule

`default_nettype wire
